// ----- rtl/lsr_pkg.sv -----
// Shared widths, request codes and status type of the setpoint ramp block.
`timescale 1ns / 1ps
`default_nettype none

package lsr_pkg;

   // Field widths fixed by the word formats.
   localparam int REQ_W   = 2;
   localparam int TIME_W  = 32;
   localparam int LEVEL_W = 14;
   localparam int DUR_W   = 24;

   // Request codes carried in req_type.
   localparam logic [REQ_W-1:0] REQ_START = 2'd0;
   localparam logic [REQ_W-1:0] REQ_STOP  = 2'd1;
   localparam logic [REQ_W-1:0] REQ_TICK  = 2'd2;

   // Status of a serial arithmetic unit.
   typedef struct packed {
      logic busy;
      logic done;
   } op_status_type;

endpackage

`default_nettype wire

// ----- rtl/lsr_if.sv -----
// Valid/ready channel interfaces for the request and response words.
`timescale 1ns / 1ps
`default_nettype none

interface lsr_req_if;
   logic                         valid;
   logic                         ready;
   logic [lsr_pkg::REQ_W-1:0]    req_type;
   logic [lsr_pkg::TIME_W-1:0]   now_ms;
   logic [lsr_pkg::LEVEL_W-1:0]  start_level;
   logic                         use_current;
   logic [lsr_pkg::LEVEL_W-1:0]  current_level;
   logic [lsr_pkg::LEVEL_W-1:0]  end_level;
   logic [lsr_pkg::DUR_W-1:0]    duration_ms;

   modport source (
      output valid, req_type, now_ms, start_level, use_current, current_level,
             end_level, duration_ms,
      input  ready
   );
   modport sink (
      input  valid, req_type, now_ms, start_level, use_current, current_level,
             end_level, duration_ms,
      output ready
   );
endinterface

interface lsr_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [lsr_pkg::LEVEL_W-1:0]  level;
   logic                         level_valid;
   logic                         done_res;
   logic                         ramp_active;

   modport source (
      output valid, level, level_valid, done_res, ramp_active,
      input  ready
   );
   modport sink (
      input  valid, level, level_valid, done_res, ramp_active,
      output ready
   );
endinterface

`default_nettype wire

// ----- rtl/lsr_mul.sv -----
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle, MSB first.
`timescale 1ns / 1ps
`default_nettype none

module lsr_mul #(
   parameter int A_W = 14,
   parameter int B_W = 24
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [A_W-1:0]        mcand,
   input  wire logic [B_W-1:0]        mplier,
   output logic      [A_W+B_W-1:0]    product,
   output lsr_pkg::op_status_type     status
);

   localparam int P_W   = A_W + B_W;
   localparam int CNT_W = $clog2(B_W + 1);

   logic [P_W-1:0]   acc_ff;
   logic [P_W-1:0]   acc_in;
   logic [A_W-1:0]   mcand_ff;
   logic [B_W-1:0]   mplier_ff;
   logic [CNT_W-1:0] count_ff;
   logic             busy_ff;
   logic             done_ff;

   // Doubling the partial sum and adding the multiplicand when the next multiplier bit is set.
   assign acc_in = {acc_ff[P_W-2:0], 1'b0} +
                   (mplier_ff[B_W-1] ? P_W'(mcand_ff) : '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            acc_ff    <= '0;
            mcand_ff  <= mcand;
            mplier_ff <= mplier;
            count_ff  <= CNT_W'(B_W);
            busy_ff   <= 1'b1;
         end else if (busy_ff) begin
            acc_ff    <= acc_in;
            mplier_ff <= {mplier_ff[B_W-2:0], 1'b0};
            count_ff  <= count_ff - CNT_W'(1);
            if (count_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign product     = acc_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

`default_nettype wire

// ----- rtl/lsr_div.sv -----
// Restoring divider that yields one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module lsr_div #(
   parameter int Q_W = 14,
   parameter int D_W = 24
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [Q_W+D_W-1:0]    dividend,
   input  wire logic [D_W-1:0]        divisor,
   output logic      [Q_W-1:0]        quotient,
   output lsr_pkg::op_status_type     status
);

   localparam int CNT_W = $clog2(Q_W + 1);

   logic [D_W-1:0]   rem_ff;
   logic [Q_W-1:0]   low_ff;
   logic [D_W-1:0]   dvs_ff;
   logic [Q_W-1:0]   quo_ff;
   logic [CNT_W-1:0] count_ff;
   logic             busy_ff;
   logic             done_ff;
   logic [D_W:0]     trial;
   logic [D_W:0]     rem_in;
   logic             fits;

   // The quotient is known to fit in Q_W bits, so the upper part of the
   // dividend is already below the divisor and serves as the first remainder.
   assign trial  = {rem_ff, low_ff[Q_W-1]};
   assign fits   = trial >= {1'b0, dvs_ff};
   assign rem_in = trial - {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            rem_ff   <= dividend[Q_W+D_W-1:Q_W];
            low_ff   <= dividend[Q_W-1:0];
            dvs_ff   <= divisor;
            quo_ff   <= '0;
            count_ff <= CNT_W'(Q_W);
            busy_ff  <= 1'b1;
         end else if (busy_ff) begin
            rem_ff   <= fits ? rem_in[D_W-1:0] : trial[D_W-1:0];
            low_ff   <= {low_ff[Q_W-2:0], 1'b0};
            quo_ff   <= {quo_ff[Q_W-2:0], fits};
            count_ff <= count_ff - CNT_W'(1);
            if (count_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign quotient    = quo_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

`default_nettype wire

// ----- rtl/linear_setpoint_ramp.sv -----
// Top level of the linear setpoint ramp generator.
//
// Requests arrive as words on req_bus (valid/ready); each one yields exactly one word on
// rsp_bus. A start word records the start and end levels (both limited to LEVEL_MAX),
// the duration and the time stamp, and answers with the start level. A tick word answers
// with the interpolated level, or with the end level and done once the elapsed time has
// reached the duration. A stop word, a tick while idle and an unused code answer with
// level_valid low and level zero.
// One word is processed at a time. Start, stop, idle ticks, completing ticks and unused
// codes pass from ST_EXEC straight to ST_OUT, which loads the output register. An
// interpolating tick first runs a bit-serial multiply over the min(DURATION_BITS, 24)
// duration bits and then a restoring divide that yields one quotient bit per level bit.
// The response sits in an output register, so the next request word is taken as soon as
// the previous one has been handed to that register, even while the receiver stalls;
// a second response then waits in the block until the register is emptied.
// Synchronous reset clears the ramp state to inactive with all levels and times zero.
`timescale 1ns / 1ps
`default_nettype none

module linear_setpoint_ramp #(
   parameter int LEVEL_MAX     = 10000,
   parameter int DURATION_BITS = 24
) (
   input  wire logic  clock,
   input  wire logic  reset,
   lsr_req_if.sink    req_bus,
   lsr_rsp_if.source  rsp_bus
);

   localparam int LW        = lsr_pkg::LEVEL_W;
   localparam int TW        = lsr_pkg::TIME_W;
   localparam int DW        = lsr_pkg::DUR_W;
   // Durations are held only as wide as both the field and the parameter allow.
   localparam int LEN_W     = (DURATION_BITS < DW) ? DURATION_BITS : DW;
   localparam int LVL_TOP   = (1 << LW) - 1;
   localparam int CAP_INT   = (LEVEL_MAX < LVL_TOP) ? LEVEL_MAX : LVL_TOP;
   localparam logic [LW-1:0] LEVEL_CAP = LW'(CAP_INT);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_MUL,
      ST_DIV,
      ST_OUT
   } state_type;

   state_type state_ff;

   // Latched request word.
   logic [lsr_pkg::REQ_W-1:0] req_type_ff;
   logic [TW-1:0]             now_ff;
   logic [LW-1:0]             start_lvl_ff;
   logic                      use_cur_ff;
   logic [LW-1:0]             cur_lvl_ff;
   logic [LW-1:0]             end_lvl_ff;
   logic [DW-1:0]             dur_ff;

   // Ramp state.
   logic                      active_ff;
   logic [LW-1:0]             ramp_start_ff;
   logic [LW-1:0]             ramp_end_ff;
   logic [TW-1:0]             start_time_ff;
   logic [LEN_W-1:0]          ramp_len_ff;

   // Pending result and output register.
   logic [LW-1:0]             res_level_ff;
   logic                      res_lvalid_ff;
   logic                      res_done_ff;
   logic                      res_active_ff;
   logic                      rsp_valid_ff;
   logic [LW-1:0]             rsp_level_ff;
   logic                      rsp_lvalid_ff;
   logic                      rsp_done_ff;
   logic                      rsp_active_ff;

   logic [TW-1:0]             elapsed;
   logic                      reached;
   logic                      ramp_up;
   logic [LW-1:0]             span;
   logic                      mul_start;
   logic                      div_start;
   logic [LW+LEN_W-1:0]       product;
   logic [LW-1:0]             quotient;
   lsr_pkg::op_status_type    mul_st;
   lsr_pkg::op_status_type    div_st;

   function automatic logic [LW-1:0] sat_level(input logic [LW-1:0] v);
      return (v > LEVEL_CAP) ? LEVEL_CAP : v;
   endfunction

   // Elapsed time wraps modulo 2^32, so a plain subtraction does it.
   assign elapsed = now_ff - start_time_ff;
   assign reached = elapsed >= TW'(ramp_len_ff);
   assign ramp_up = ramp_end_ff >= ramp_start_ff;
   assign span    = ramp_up ? (ramp_end_ff - ramp_start_ff) : (ramp_start_ff - ramp_end_ff);

   assign mul_start = (state_ff == ST_EXEC) && (req_type_ff == lsr_pkg::REQ_TICK) &&
                      active_ff && !reached;
   assign div_start = (state_ff == ST_MUL) && mul_st.done;

   // The interpolation magnitude is span * elapsed / length, below span unless span is zero.
   lsr_mul #(
      .A_W (LW),
      .B_W (LEN_W)
   ) u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .mcand   (span),
      .mplier  (elapsed[LEN_W-1:0]),
      .product (product),
      .status  (mul_st)
   );

   lsr_div #(
      .Q_W (LW),
      .D_W (LEN_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (product),
      .divisor  (ramp_len_ff),
      .quotient (quotient),
      .status   (div_st)
   );

   assign req_bus.ready = (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         active_ff     <= 1'b0;
         ramp_start_ff <= '0;
         ramp_end_ff   <= '0;
         start_time_ff <= '0;
         ramp_len_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         // While a result is being handed over, ST_OUT itself refills the register.
         if (rsp_valid_ff && rsp_bus.ready && (state_ff != ST_OUT)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_bus.valid) begin
                  req_type_ff  <= req_bus.req_type;
                  now_ff       <= req_bus.now_ms;
                  start_lvl_ff <= req_bus.start_level;
                  use_cur_ff   <= req_bus.use_current;
                  cur_lvl_ff   <= req_bus.current_level;
                  end_lvl_ff   <= req_bus.end_level;
                  dur_ff       <= req_bus.duration_ms;
                  state_ff     <= ST_EXEC;
               end
            end
            ST_EXEC: begin
               unique case (req_type_ff)
                  lsr_pkg::REQ_START: begin
                     ramp_start_ff <= sat_level(use_cur_ff ? cur_lvl_ff : start_lvl_ff);
                     ramp_end_ff   <= sat_level(end_lvl_ff);
                     ramp_len_ff   <= dur_ff[LEN_W-1:0];
                     start_time_ff <= now_ff;
                     active_ff     <= 1'b1;
                     res_level_ff  <= sat_level(use_cur_ff ? cur_lvl_ff : start_lvl_ff);
                     res_lvalid_ff <= 1'b1;
                     res_done_ff   <= 1'b0;
                     res_active_ff <= 1'b1;
                     state_ff      <= ST_OUT;
                  end
                  lsr_pkg::REQ_STOP: begin
                     active_ff     <= 1'b0;
                     res_level_ff  <= '0;
                     res_lvalid_ff <= 1'b0;
                     res_done_ff   <= 1'b0;
                     res_active_ff <= 1'b0;
                     state_ff      <= ST_OUT;
                  end
                  lsr_pkg::REQ_TICK: begin
                     if (!active_ff) begin
                        res_level_ff  <= '0;
                        res_lvalid_ff <= 1'b0;
                        res_done_ff   <= 1'b0;
                        res_active_ff <= 1'b0;
                        state_ff      <= ST_OUT;
                     end else if (reached) begin
                        res_level_ff  <= ramp_end_ff;
                        res_lvalid_ff <= 1'b1;
                        res_done_ff   <= 1'b1;
                        res_active_ff <= 1'b0;
                        active_ff     <= 1'b0;
                        state_ff      <= ST_OUT;
                     end else begin
                        // The level itself is filled in when the divide finishes.
                        res_lvalid_ff <= 1'b1;
                        res_done_ff   <= 1'b0;
                        res_active_ff <= 1'b1;
                        state_ff      <= ST_MUL;
                     end
                  end
                  default: begin
                     // Unused code: state untouched, nothing to apply.
                     res_level_ff  <= '0;
                     res_lvalid_ff <= 1'b0;
                     res_done_ff   <= 1'b0;
                     res_active_ff <= active_ff;
                     state_ff      <= ST_OUT;
                  end
               endcase
            end
            ST_MUL: begin
               if (mul_st.done) begin
                  state_ff <= ST_DIV;
               end
            end
            ST_DIV: begin
               if (div_st.done) begin
                  res_level_ff <= ramp_up ? (ramp_start_ff + quotient)
                                          : (ramp_start_ff - quotient);
                  state_ff     <= ST_OUT;
               end
            end
            ST_OUT: begin
               if (!rsp_valid_ff || rsp_bus.ready) begin
                  rsp_level_ff  <= res_level_ff;
                  rsp_lvalid_ff <= res_lvalid_ff;
                  rsp_done_ff   <= res_done_ff;
                  rsp_active_ff <= res_active_ff;
                  rsp_valid_ff  <= 1'b1;
                  state_ff      <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.level       = rsp_level_ff;
   assign rsp_bus.level_valid = rsp_lvalid_ff;
   assign rsp_bus.done_res    = rsp_done_ff;
   assign rsp_bus.ramp_active = rsp_active_ff;

   // A completed ramp always reports a level and an inactive flag.
   a_done_clears_active: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_done_ff) |-> (rsp_lvalid_ff && !rsp_active_ff))
      else $error("done word with active ramp or without level");

   // A word with nothing to apply carries a zero level.
   a_idle_level_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_lvalid_ff) |-> (rsp_level_ff == '0))
      else $error("nonzero level in a word with level_valid low");

   // An accepted request word is processed in the following cycle.
   a_accept_to_exec: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> (state_ff == ST_EXEC))
      else $error("accepted request not taken into execution");

   // The sequencer waits on the multiplier only while it is running or finishing.
   a_mul_running: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL) |-> (mul_st.busy || mul_st.done))
      else $error("waiting on an idle multiplier");

   // The same holds for the divider.
   a_div_running: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (div_st.busy || div_st.done))
      else $error("waiting on an idle divider");

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
// Self-checking testbench for the linear setpoint ramp generator.
`timescale 1ns / 1ps

module testbench;

   // Field widths and request codes, taken from the package.
   localparam int REQ_W   = lsr_pkg::REQ_W;
   localparam int TIME_W  = lsr_pkg::TIME_W;
   localparam int LEVEL_W = lsr_pkg::LEVEL_W;
   localparam int DUR_W   = lsr_pkg::DUR_W;
   localparam logic [REQ_W-1:0] REQ_START = lsr_pkg::REQ_START;
   localparam logic [REQ_W-1:0] REQ_STOP  = lsr_pkg::REQ_STOP;
   localparam logic [REQ_W-1:0] REQ_TICK  = lsr_pkg::REQ_TICK;

   // The block is built with its default sizes, and the predictor uses the same ones.
   localparam int LEVEL_MAX     = 10000;
   localparam int DURATION_BITS = 24;
   localparam int LEVEL_TOP     = (1 << LEVEL_W) - 1;

   // The package names only the three live request codes; the fourth must be ignored.
   localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

   // The watchdog limit leaves room for an interpolating tick plus a receiver that stalls
   // 84 times in a hundred, many times over.
   localparam int STALL_LIMIT     = 5000;
   localparam int DRAIN_CYCLES    = 100;
   localparam int WORDS_PER_PHASE = 300;

   typedef struct packed {
      logic [REQ_W-1:0]   req_type;
      logic [TIME_W-1:0]  now_ms;
      logic [LEVEL_W-1:0] start_level;
      logic               use_current;
      logic [LEVEL_W-1:0] current_level;
      logic [LEVEL_W-1:0] end_level;
      logic [DUR_W-1:0]   duration_ms;
   } ramp_req_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] level;
      logic               level_valid;
      logic               done_res;
      logic               ramp_active;
   } ramp_rsp_type;

   // One row of the directed table. When typed is set, want holds a response word that
   // can be read straight off the behavior; otherwise the predictor supplies it.
   typedef struct {
      ramp_req_type word;
      bit           typed;
      ramp_rsp_type want;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset;

   lsr_req_if req_bus ();
   lsr_rsp_if rsp_bus ();

   linear_setpoint_ramp #(
      .LEVEL_MAX     (LEVEL_MAX),
      .DURATION_BITS (DURATION_BITS)
   ) u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Predicted ramp state, kept in step with every accepted request word.
   logic               ramp_on;
   logic [LEVEL_W-1:0] ramp_from;
   logic [LEVEL_W-1:0] ramp_to;
   logic [TIME_W-1:0]  ramp_t0;
   logic [DUR_W-1:0]   ramp_len;

   // Response words still owed by the block, oldest first.
   ramp_rsp_type levels_due[$];

   int faults;
   int words_sent;
   int stall_cycles;
   int req_idle_pct;
   int rsp_idle_pct;

   stim_row_type dir_rows[$];

   function automatic logic [LEVEL_W-1:0] clamp_level(logic [LEVEL_W-1:0] v);
      return (v > LEVEL_MAX) ? LEVEL_W'(LEVEL_MAX) : v;
   endfunction

   // Applies one request word to the predicted state and returns the response word that
   // it must produce. Interpolation truncates toward zero in both ramp directions.
   function automatic ramp_rsp_type advance_ramp(ramp_req_type w);
      ramp_rsp_type      r;
      logic [TIME_W-1:0] elapsed;
      logic [63:0]       span;
      logic [63:0]       step;
      r = '0;
      case (w.req_type)
         REQ_START: begin
            ramp_from = clamp_level(w.use_current ? w.current_level : w.start_level);
            ramp_to   = clamp_level(w.end_level);
            ramp_len  = w.duration_ms & DUR_W'((64'd1 << DURATION_BITS) - 1);
            ramp_t0   = w.now_ms;
            ramp_on   = 1'b1;
            r.level       = ramp_from;
            r.level_valid = 1'b1;
         end
         REQ_STOP: begin
            ramp_on = 1'b0;
         end
         REQ_TICK: begin
            if (ramp_on) begin
               // The elapsed time wraps modulo 2^32, so a tick stamped before the start
               // looks like a very long wait and completes the ramp.
               elapsed = w.now_ms - ramp_t0;
               if (elapsed >= TIME_W'(ramp_len)) begin
                  r.level    = ramp_to;
                  r.done_res = 1'b1;
                  ramp_on    = 1'b0;
               end else if (ramp_to >= ramp_from) begin
                  span    = 64'(ramp_to - ramp_from);
                  step    = (span * 64'(elapsed)) / 64'(ramp_len);
                  r.level = ramp_from + LEVEL_W'(step);
               end else begin
                  span    = 64'(ramp_from - ramp_to);
                  step    = (span * 64'(elapsed)) / 64'(ramp_len);
                  r.level = ramp_from - LEVEL_W'(step);
               end
               r.level_valid = 1'b1;
            end
         end
         default: begin
         end
      endcase
      r.ramp_active = ramp_on;
      return r;
   endfunction

   function automatic stim_row_type dir_row(logic [REQ_W-1:0] req, logic [TIME_W-1:0] now,
                                            int from, bit use_cur, int cur, int to,
                                            logic [DUR_W-1:0] dur, bit typed, int lvl,
                                            bit lv, bit dn, bit act);
      stim_row_type row;
      row.word  = '{req, now, LEVEL_W'(from), use_cur, LEVEL_W'(cur), LEVEL_W'(to), dur};
      row.typed = typed;
      row.want  = '{LEVEL_W'(lvl), lv, dn, act};
      return row;
   endfunction

   // Every field random over its full width, so that unused fields also toggle.
   function automatic ramp_req_type random_word();
      ramp_req_type w;
      w.req_type      = REQ_W'($urandom);
      w.now_ms        = $urandom;
      w.start_level   = LEVEL_W'($urandom);
      w.use_current   = 1'($urandom);
      w.current_level = LEVEL_W'($urandom);
      w.end_level     = LEVEL_W'($urandom);
      w.duration_ms   = DUR_W'($urandom);
      return w;
   endfunction

   // Mostly legal levels, with a share above the limit and a share at the two ends.
   function automatic logic [LEVEL_W-1:0] pick_level();
      int roll;
      roll = $urandom_range(99);
      if (roll < 12)
         return LEVEL_W'($urandom_range(LEVEL_MAX + 1, LEVEL_TOP));
      else if (roll < 24)
         return $urandom_range(1) ? LEVEL_W'(LEVEL_MAX) : '0;
      return LEVEL_W'($urandom_range(0, LEVEL_MAX));
   endfunction

   // Short ramps dominate so that ticks walk through them; long ones exercise the full
   // duration width, and zero checks the finish on the first tick.
   function automatic logic [DUR_W-1:0] pick_duration();
      int roll;
      roll = $urandom_range(99);
      if (roll < 12)
         return '0;
      else if (roll < 30)
         return DUR_W'($urandom);
      else if (roll < 40)
         return DUR_W'($urandom_range(1, 4));
      return DUR_W'($urandom_range(1, 400));
   endfunction

   function automatic ramp_req_type start_word(logic [TIME_W-1:0] t, logic [DUR_W-1:0] len);
      ramp_req_type w;
      w               = random_word();
      w.req_type      = REQ_START;
      w.now_ms        = t;
      w.start_level   = pick_level();
      w.current_level = pick_level();
      w.end_level     = pick_level();
      w.duration_ms   = len;
      return w;
   endfunction

   // Offers one request word, with random idle cycles ahead of it, and records the
   // response it is owed once it has been taken. Valid stays high into the next word
   // when no idle cycle falls between them.
   task automatic send_word(ramp_req_type w, bit typed = 1'b0, ramp_rsp_type want = '0);
      ramp_rsp_type predicted;
      while ($urandom_range(99) < req_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.req_type      <= w.req_type;
      req_bus.now_ms        <= w.now_ms;
      req_bus.start_level   <= w.start_level;
      req_bus.use_current   <= w.use_current;
      req_bus.current_level <= w.current_level;
      req_bus.end_level     <= w.end_level;
      req_bus.duration_ms   <= w.duration_ms;
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
      predicted = advance_ramp(w);
      levels_due.push_back(typed ? want : predicted);
      if (w.req_type != REQ_UNUSED)
         words_sent++;
   endtask

   // Holds the request side idle until every owed response word has arrived.
   task automatic pause_until_drained();
      req_bus.valid <= 1'b0;
      while (levels_due.size() != 0)
         @(posedge clock);
   endtask

   // One burst of random stimulus. Most bursts are a start followed by ticks that move
   // forward through the ramp, with stops, restarts, unused codes and time jumps mixed
   // in; a few are pure noise. Half the ramps get a tick past the end to complete them.
   task automatic run_ramp_sequence();
      ramp_req_type      w;
      logic [TIME_W-1:0] t;
      logic [DUR_W-1:0]  len;
      int                roll;
      roll = $urandom_range(99);
      if (roll < 8) begin
         repeat ($urandom_range(1, 4))
            send_word(random_word());
         return;
      end
      t   = $urandom;
      len = pick_duration();
      send_word(start_word(t, len));
      repeat ($urandom_range(1, 10)) begin
         roll = $urandom_range(99);
         w    = random_word();
         if (roll < 5) begin
            w.req_type = REQ_STOP;
         end else if (roll < 9) begin
            w.req_type = REQ_UNUSED;
         end else if (roll < 13) begin
            len = pick_duration();
            w   = start_word(t, len);
         end else begin
            w.req_type = REQ_TICK;
            if (roll < 17)
               t = $urandom;
            else
               t = t + $urandom_range(0, (len >> 2) + 2);
            w.now_ms = t;
         end
         send_word(w);
      end
      if ($urandom_range(1)) begin
         w          = random_word();
         w.req_type = REQ_TICK;
         w.now_ms   = t + len + $urandom_range(0, 3);
         send_word(w);
      end
   endtask

   task automatic check_field(string name, int want, int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         faults++;
      end
   endtask

   // Response side: every taken word is compared with the oldest owed one. Ready is
   // drawn fresh every cycle from the current stall rate.
   always @(posedge clock) begin : rsp_side
      ramp_rsp_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (levels_due.size() == 0) begin
            $error("response word with none owed: level %0d, level_valid %0d",
                   rsp_bus.level, rsp_bus.level_valid);
            faults++;
         end else begin
            want = levels_due.pop_front();
            check_field("level", want.level, rsp_bus.level);
            check_field("level_valid", want.level_valid, rsp_bus.level_valid);
            check_field("done_res", want.done_res, rsp_bus.done_res);
            check_field("ramp_active", want.ramp_active, rsp_bus.ramp_active);
         end
      end
      rsp_bus.ready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   // Watchdog: ends the run when neither side has moved a word for too long.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin : main
      req_bus.valid         = 1'b0;
      req_bus.req_type      = REQ_START;
      req_bus.now_ms        = '0;
      req_bus.start_level   = '0;
      req_bus.use_current   = 1'b0;
      req_bus.current_level = '0;
      req_bus.end_level     = '0;
      req_bus.duration_ms   = '0;
      rsp_bus.ready         = 1'b0;
      reset                 = 1'b1;
      ramp_on      = 1'b0;
      ramp_from    = '0;
      ramp_to      = '0;
      ramp_t0      = '0;
      ramp_len     = '0;
      faults       = 0;
      words_sent   = 0;
      stall_cycles = 0;
      req_idle_pct = 38;
      rsp_idle_pct = 84;

      // Directed table: idle responses after reset, the ignored code, both ramp
      // directions, level saturation, the start level taken from the caller, a zero
      // duration, a restart while active, time wrap and the widest duration.
      dir_rows.push_back(dir_row(REQ_TICK, 32'd1000, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0));
      dir_rows.push_back(dir_row(REQ_STOP, 32'd1000, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0));
      dir_rows.push_back(dir_row(REQ_UNUSED, 32'hFFFF_FFFF, LEVEL_TOP, 1, LEVEL_TOP,
                                 LEVEL_TOP, 24'hFF_FFFF, 1, 0, 0, 0, 0));
      dir_rows.push_back(dir_row(REQ_START, 32'd1000, 0, 0, 0, 10000, 1000,
                                 1, 0, 1, 0, 1));
      dir_rows.push_back(dir_row(REQ_TICK, 32'd1500, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      dir_rows.push_back(dir_row(REQ_TICK, 32'd1999, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      dir_rows.push_back(dir_row(REQ_TICK, 32'd2000, 0, 0, 0, 0, 0, 1, 10000, 1, 1, 0));
      dir_rows.push_back(dir_row(REQ_TICK, 32'd2100, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0));
      dir_rows.push_back(dir_row(REQ_START, 32'd3000, LEVEL_TOP, 0, 0, LEVEL_TOP, 20,
                                 1, 10000, 1, 0, 1));
      dir_rows.push_back(dir_row(REQ_UNUSED, 32'd3005, LEVEL_TOP, 1, LEVEL_TOP,
                                 LEVEL_TOP, 24'hFF_FFFF, 1, 0, 0, 0, 1));
      dir_rows.push_back(dir_row(REQ_STOP, 32'd3006, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0));
      dir_rows.push_back(dir_row(REQ_START, 32'hFFFF_FFF0, 5, 1, LEVEL_TOP, 0,
                                 24'hFF_FFFF, 1, 10000, 1, 0, 1));
      dir_rows.push_back(dir_row(REQ_TICK, 32'h0000_1000, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      dir_rows.push_back(dir_row(REQ_START, 32'd0, 9999, 1, 2500, 7500, 0,
                                 1, 2500, 1, 0, 1));
      dir_rows.push_back(dir_row(REQ_TICK, 32'd0, 0, 0, 0, 0, 0, 1, 7500, 1, 1, 0));
      dir_rows.push_back(dir_row(REQ_START, 32'd100, 10000, 0, 0, 0, 3,
                                 1, 10000, 1, 0, 1));
      dir_rows.push_back(dir_row(REQ_TICK, 32'd101, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      dir_rows.push_back(dir_row(REQ_START, 32'd200, 1234, 0, 0, 4321, 50,
                                 1, 1234, 1, 0, 1));
      dir_rows.push_back(dir_row(REQ_TICK, 32'd199, 0, 0, 0, 0, 0, 1, 4321, 1, 1, 0));
      dir_rows.push_back(dir_row(REQ_START, 32'd0, 0, 0, 0, 10000, 24'hFF_FFFF,
                                 1, 0, 1, 0, 1));
      dir_rows.push_back(dir_row(REQ_TICK, 32'd16777214, 0, 0, 0, 0, 0,
                                 0, 0, 0, 0, 0));
      dir_rows.push_back(dir_row(REQ_TICK, 32'hFFFF_FFFF, 0, 0, 0, 0, 0,
                                 1, 10000, 1, 1, 0));

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i])
         send_word(dir_rows[i].word, dir_rows[i].typed, dir_rows[i].want);
      pause_until_drained();

      // First random phase: sender idles often, receiver stalls most of the time.
      while (words_sent < WORDS_PER_PHASE)
         run_ramp_sequence();
      pause_until_drained();

      // Second phase: the rates swap, so the block mostly waits on the request side.
      req_idle_pct = 84;
      rsp_idle_pct = 38;
      while (words_sent < 2 * WORDS_PER_PHASE)
         run_ramp_sequence();
      pause_until_drained();

      // Last phase: both sides run flat out.
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      while (words_sent < 3 * WORDS_PER_PHASE)
         run_ramp_sequence();
      pause_until_drained();

      // Quiet tail: any extra response word shows up here as one with none owed.
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (faults == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
